FILE: hw/rtl/fmo_pkg.sv
`timescale 1ns / 1ps

package fmo_pkg;

  // Envelope full scale: 2^24 equals a level of one.
  localparam logic [24:0] FULL_SCALE = 25'h100_0000;

  // Shared multiplier operand and product widths (signed).
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_NOTE_ON  = 2'd1,
    REQ_NOTE_OFF = 2'd2,
    REQ_RESET    = 2'd3
  } req_t;

  // Envelope stages.
  typedef enum logic [2:0] {
    ENV_IDLE    = 3'd0,
    ENV_ATTACK  = 3'd1,
    ENV_DECAY   = 3'd2,
    ENV_SUSTAIN = 3'd3,
    ENV_RELEASE = 3'd4
  } env_stage_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_FREQ_RATIO      = 3'd0,
    CFG_FEEDBACK_AMOUNT = 3'd1,
    CFG_SUSTAIN_LEVEL   = 3'd2,
    CFG_ATTACK_STEP     = 3'd3,
    CFG_DECAY_STEP      = 3'd4,
    CFG_RELEASE_STEP    = 3'd5,
    CFG_PHASE_PER_HZ    = 3'd6
  } cfg_reg_t;

  // One sine table entry for phase t (2^32 per turn), scaled to amp.
  // Quadrant folding followed by a Q30 Taylor series; evaluated at elaboration.
  function automatic int sine_entry(logic [31:0] t, int amp);
    logic [1:0]  q;
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    longint      sum;
    longint      e;
    q = t[31:30];
    r = {34'd0, t[29:0]};
    if (q[0]) begin
      r = 64'd1073741824 - r;
    end
    a    = (r * 64'd1686629713) >> 30;
    a2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    for (int n = 1; n <= 6; n++) begin
      term = (term * a2) >> 30;
      unique case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    e = (sum * longint'(amp) + (64'sd1 <<< 29)) >>> 30;
    if (e > longint'(amp)) begin
      e = longint'(amp);
    end
    return q[1] ? -int'(e) : int'(e);
  endfunction

endpackage

FILE: hw/rtl/fm_operator_with_adsr_unit.sv
`timescale 1ns / 1ps

// FM operator with a five-stage envelope.
// Input channel (in_*): one transfer carries a request. in_tuser is the kind
// (tick, note on, note off, reset); in_tdata holds the note frequency (Q16.16 Hz)
// in bits 31:0 and the signed phase modulation in bits 63:32.
// Output channel (out_*): each tick gives one transfer with the envelope-scaled
// sample in out_tdata and the voice-active flag in out_tuser. Other kinds give none.
// Configuration is a write port (cfg_we, cfg_index, cfg_data), written when idle;
// the block does not enforce this, so the user must keep to it. A tick runs its
// steps in order on one shared multiplier (feedback, table address, table read,
// envelope product, output load). A note on forms the phase step: a 48 by 40 bit
// product cut into four partial products. Note off and reset act on acceptance.
// The sine table is a constant ROM with a registered read.
// Reset sets the registers to their defaults and the voice to idle.
// The result sits in an output register; the next item is taken while it waits,
// and a tick only stalls in its output load step if the last result was not taken.
module fm_operator_with_adsr_unit #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH     = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [63:0]                           in_tdata,   // note_frequency, modulation_phase
  input  logic [1:0]                            in_tuser,   // req_type
  // Result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     out_tdata,  // sample_out, zero pad
  output logic                                  out_tuser,  // voice_active
  // Configuration port
  input  logic                                  cfg_we,
  input  logic [2:0]                            cfg_index,
  input  logic [39:0]                           cfg_data
);

  localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH);
  localparam int OUT_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int SINE_AMP = 2 ** (SAMPLE_WIDTH - 1) - 1;
  localparam int A_W      = fmo_pkg::MUL_A_W;
  localparam int B_W      = fmo_pkg::MUL_B_W;
  localparam int P_W      = fmo_pkg::PROD_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ON_A,
    S_ON_B,
    S_ON_C,
    S_ON_D,
    S_ON_E,
    S_ON_F,
    S_T_FB,
    S_T_ADDR,
    S_T_ROM,
    S_T_MUL,
    S_T_OUT
  } seq_t;

  // Sine ROM, built at elaboration.
  logic signed [SAMPLE_WIDTH-1:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] T_K = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
    assign sine_rom[k] = SAMPLE_WIDTH'(fmo_pkg::sine_entry(T_K[31:0], SINE_AMP));
  end

  // Control and architectural state
  seq_t                      state_r;
  logic                      out_valid_r;
  logic [15:0]               freq_ratio_r;
  logic [14:0]               feedback_amount_r;
  logic [24:0]               sustain_level_r;
  logic [24:0]               attack_step_r;
  logic [24:0]               decay_step_r;
  logic [24:0]               release_step_r;
  logic [39:0]               phase_per_hz_r;
  logic [31:0]               phase_accum_r;
  logic [31:0]               phase_step_r;
  logic signed [SAMPLE_WIDTH-1:0] last_sine_r;
  fmo_pkg::env_stage_t       env_stage_r;
  logic [24:0]               env_level_r;

  // Datapath registers
  logic [31:0]               freq_r;
  logic [31:0]               mod_r;
  logic signed [P_W-1:0]     prod_r;
  logic [47:0]               a_r;
  logic [51:0]               acc_r;
  logic signed [SAMPLE_WIDTH-1:0] sine_r;
  logic [SAMPLE_WIDTH-1:0]   sample_r;
  logic                      active_r;

  // Combinational helpers
  logic signed [A_W-1:0]     mul_a;
  logic signed [B_W-1:0]     mul_b;
  logic signed [P_W-1:0]     mul_p;
  logic signed [P_W+16:0]    fb_full;
  logic [31:0]               addr;
  logic [IDX_W-1:0]          rom_idx;
  logic [51:0]               step_sum;
  logic signed [P_W-1:0]     smp_sum;
  logic [24:0]               sus_lvl;
  logic [25:0]               att_sum;
  logic signed [26:0]        dec_diff;
  logic signed [26:0]        rel_diff;
  fmo_pkg::env_stage_t       env_stage_nxt;
  logic [24:0]               env_level_nxt;
  logic                      in_xfer;
  logic                      out_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_T_OUT) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(sample_r);
  assign out_tuser  = active_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_ON_A: begin
        mul_a = {1'b0, freq_r};
        mul_b = {10'd0, freq_ratio_r};
      end
      S_ON_B: begin
        mul_a = {9'd0, prod_r[23:0]};
        mul_b = {6'd0, phase_per_hz_r[19:0]};
      end
      S_ON_C: begin
        mul_a = {9'd0, a_r[23:0]};
        mul_b = {6'd0, phase_per_hz_r[39:20]};
      end
      S_ON_D: begin
        mul_a = {9'd0, a_r[47:24]};
        mul_b = {6'd0, phase_per_hz_r[19:0]};
      end
      S_ON_E: begin
        mul_a = {9'd0, a_r[47:24]};
        mul_b = {6'd0, phase_per_hz_r[39:20]};
      end
      S_T_FB: begin
        mul_a = {{(A_W-SAMPLE_WIDTH){last_sine_r[SAMPLE_WIDTH-1]}}, last_sine_r};
        mul_b = {11'd0, feedback_amount_r};
      end
      S_T_ADDR: begin
        mul_a = {1'b0, addr};
        mul_b = B_W'(SINE_TABLE_DEPTH);
      end
      // The envelope product is held while the output register is full.
      S_T_MUL, S_T_OUT: begin
        mul_a = {{(A_W-SAMPLE_WIDTH){sine_r[SAMPLE_WIDTH-1]}}, sine_r};
        mul_b = {1'b0, env_level_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Feedback offset, table address and index.
  assign fb_full  = $signed({prod_r, 17'd0}) >>> (SAMPLE_WIDTH - 1);
  assign addr     = phase_accum_r + mod_r + fb_full[31:0];
  assign rom_idx  = prod_r[32 +: IDX_W];
  assign step_sum = acc_r + {prod_r[27:0], 24'd0};
  assign smp_sum  = prod_r + P_W'(64'sd8388608);

  // Envelope step for one tick.
  always_comb begin
    sus_lvl  = (sustain_level_r > fmo_pkg::FULL_SCALE) ? fmo_pkg::FULL_SCALE
                                                       : sustain_level_r;
    att_sum  = {1'b0, env_level_r} + {1'b0, attack_step_r};
    dec_diff = $signed({2'b0, env_level_r}) - $signed({2'b0, decay_step_r});
    rel_diff = $signed({2'b0, env_level_r}) - $signed({2'b0, release_step_r});
    env_stage_nxt = env_stage_r;
    env_level_nxt = env_level_r;
    unique case (env_stage_r)
      fmo_pkg::ENV_ATTACK: begin
        if (att_sum >= {1'b0, fmo_pkg::FULL_SCALE}) begin
          env_level_nxt = fmo_pkg::FULL_SCALE;
          env_stage_nxt = fmo_pkg::ENV_DECAY;
        end else begin
          env_level_nxt = att_sum[24:0];
        end
      end
      fmo_pkg::ENV_DECAY: begin
        if (dec_diff <= $signed({2'b0, sus_lvl})) begin
          env_level_nxt = sus_lvl;
          env_stage_nxt = fmo_pkg::ENV_SUSTAIN;
        end else begin
          env_level_nxt = dec_diff[24:0];
        end
      end
      fmo_pkg::ENV_SUSTAIN: begin
        env_level_nxt = sus_lvl;
      end
      fmo_pkg::ENV_RELEASE: begin
        if (rel_diff <= 27'sd0) begin
          env_level_nxt = '0;
          env_stage_nxt = fmo_pkg::ENV_IDLE;
        end else begin
          env_level_nxt = rel_diff[24:0];
        end
      end
      default: begin
        env_level_nxt = '0;
        env_stage_nxt = fmo_pkg::ENV_IDLE;
      end
    endcase
  end

  // Sequencer, configuration and operator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      out_valid_r       <= 1'b0;
      freq_ratio_r      <= 16'd256;
      feedback_amount_r <= '0;
      sustain_level_r   <= fmo_pkg::FULL_SCALE;
      attack_step_r     <= fmo_pkg::FULL_SCALE;
      decay_step_r      <= '0;
      release_step_r    <= fmo_pkg::FULL_SCALE;
      phase_per_hz_r    <= 40'd6388890186;
      phase_accum_r     <= '0;
      phase_step_r      <= '0;
      last_sine_r       <= '0;
      env_stage_r       <= fmo_pkg::ENV_IDLE;
      env_level_r       <= '0;
    end else begin
      // Register writes.
      if (cfg_we) begin
        unique case (fmo_pkg::cfg_reg_t'(cfg_index))
          fmo_pkg::CFG_FREQ_RATIO:      freq_ratio_r      <= cfg_data[15:0];
          fmo_pkg::CFG_FEEDBACK_AMOUNT: feedback_amount_r <= cfg_data[14:0];
          fmo_pkg::CFG_SUSTAIN_LEVEL:   sustain_level_r   <= cfg_data[24:0];
          fmo_pkg::CFG_ATTACK_STEP:     attack_step_r     <= cfg_data[24:0];
          fmo_pkg::CFG_DECAY_STEP:      decay_step_r      <= cfg_data[24:0];
          fmo_pkg::CFG_RELEASE_STEP:    release_step_r    <= cfg_data[24:0];
          fmo_pkg::CFG_PHASE_PER_HZ:    phase_per_hz_r    <= cfg_data;
          default: ;
        endcase
      end

      // The output register fills from a finished tick and empties on a transfer.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (fmo_pkg::req_t'(in_tuser))
              fmo_pkg::REQ_TICK:    state_r <= S_T_FB;
              fmo_pkg::REQ_NOTE_ON: state_r <= S_ON_A;
              fmo_pkg::REQ_NOTE_OFF: begin
                if (env_stage_r != fmo_pkg::ENV_IDLE) begin
                  env_stage_r <= fmo_pkg::ENV_RELEASE;
                end
              end
              default: begin
                phase_accum_r <= '0;
                last_sine_r   <= '0;
                env_level_r   <= '0;
                env_stage_r   <= fmo_pkg::ENV_IDLE;
              end
            endcase
          end
        end
        S_ON_A: state_r <= S_ON_B;
        S_ON_B: state_r <= S_ON_C;
        S_ON_C: state_r <= S_ON_D;
        S_ON_D: state_r <= S_ON_E;
        S_ON_E: state_r <= S_ON_F;
        S_ON_F: begin
          phase_step_r  <= step_sum[51:20];
          phase_accum_r <= '0;
          last_sine_r   <= '0;
          env_level_r   <= '0;
          env_stage_r   <= fmo_pkg::ENV_ATTACK;
          state_r       <= S_IDLE;
        end
        S_T_FB:   state_r <= S_T_ADDR;
        S_T_ADDR: state_r <= S_T_ROM;
        S_T_ROM: begin
          phase_accum_r <= phase_accum_r + phase_step_r;
          env_stage_r   <= env_stage_nxt;
          env_level_r   <= env_level_nxt;
          state_r       <= S_T_MUL;
        end
        S_T_MUL: begin
          last_sine_r <= sine_r;
          state_r     <= S_T_OUT;
        end
        S_T_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (in_xfer) begin
      freq_r <= in_tdata[31:0];
      mod_r  <= in_tdata[63:32];
    end
    if (state_r == S_ON_B) begin
      a_r <= prod_r[47:0];
    end
    // Phase step accumulation over the partial products.
    unique case (state_r)
      S_ON_C:  acc_r <= {28'd0, prod_r[43:20]};
      S_ON_D:  acc_r <= acc_r + prod_r[51:0];
      S_ON_E:  acc_r <= acc_r + {prod_r[47:0], 4'd0};
      default: acc_r <= acc_r;
    endcase
    if (state_r == S_T_ROM) begin
      sine_r <= sine_rom[rom_idx];
    end
    // The voice flag travels with its sample.
    if (out_load) begin
      sample_r <= smp_sum[24 +: SAMPLE_WIDTH];
      active_r <= (env_stage_r != fmo_pkg::ENV_IDLE);
    end
  end

  // Checks on the envelope and sequencer.
  a_level_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    env_level_r <= fmo_pkg::FULL_SCALE)
    else $error("envelope level above full scale");

  a_idle_is_silent : assert property (@(posedge clk) disable iff (!rst_n)
    env_stage_r == fmo_pkg::ENV_IDLE |-> env_level_r == '0)
    else $error("idle envelope with nonzero level");

  a_note_on_attack : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ON_F |=> env_stage_r == fmo_pkg::ENV_ATTACK && env_level_r == '0
                          && state_r == S_IDLE)
    else $error("note on did not start the attack");

  a_result_from_tick : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_T_OUT)
    else $error("result raised outside the tick output step");

endmodule
